>>> hdl/assert_macros.svh
// Assertion macros used by the checker file arh_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ARH_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("auto range histogram check failed");

// Implication form: whenever ante holds, cons holds in the same cycle.
`define ARH_ASSERT_IMP(label, ante, cons) `ARH_ASSERT(label, (ante) |-> (cons))

`endif

>>> hdl/arh_pkg.sv
`default_nettype none
package arh_pkg;

   localparam int BINS_DEFAULT  = 150;
   localparam int DEPTH_DEFAULT = 4096;
   localparam int SAMPLE_W      = 32;
   localparam int COUNT_W       = 13;
   localparam int BASE_W        = 8;
   localparam int VBINS_W       = 3;
   localparam int LANES         = 4;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic store_push;
      logic set_restart;
      logic clr_write;
      logic smp_read;
      logic mul_load;
      logic div_step;
      logic bin_read;
      logic bin_write;
      logic grp_init;
      logic grp_read;
      logic grp_cap;
      logic grp_next;
   } arh_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic flat;
      logic scan_done;
      logic div_last;
      logic lane_last;
      logic grp_last;
   } arh_status_type;

endpackage
`default_nettype wire

>>> hdl/auto_range_histogram_unit.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_sample, req_last_item
// rsp      out        rsp_valid/rsp_stall  bin_base, count_a..d, valid_bins, min/max, flags
//
// Samples are taken one per cycle until the last one of a set.
// After the last sample the bin memory is cleared. Unless the range is flat, each stored
// sample then passes through store read, multiply, one quotient bit per divider step,
// bin read and bin write. Each result carries up to four bins and is held while stalled;
// no sample is taken until the last result of the set is transferred. Reset is
// synchronous and active high.
`default_nettype none
module auto_range_histogram_unit #(
   parameter int BINS  = arh_pkg::BINS_DEFAULT,
   parameter int DEPTH = arh_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic signed [arh_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_last_item,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [arh_pkg::BASE_W-1:0]          rsp_bin_base,
   output      logic [arh_pkg::COUNT_W-1:0]         rsp_count_a,
   output      logic [arh_pkg::COUNT_W-1:0]         rsp_count_b,
   output      logic [arh_pkg::COUNT_W-1:0]         rsp_count_c,
   output      logic [arh_pkg::COUNT_W-1:0]         rsp_count_d,
   output      logic [arh_pkg::VBINS_W-1:0]         rsp_valid_bins,
   output      logic signed [arh_pkg::SAMPLE_W-1:0] rsp_min_value,
   output      logic signed [arh_pkg::SAMPLE_W-1:0] rsp_max_value,
   output      logic                                rsp_flat_range,
   output      logic                                rsp_overflowed,
   output      logic                                rsp_last_result
);

   arh_pkg::arh_cmd_type    cmd;
   arh_pkg::arh_status_type status;

   arh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   arh_datapath #(.BINS(BINS), .DEPTH(DEPTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_sample     (req_sample),
      .status         (status),
      .rsp_bin_base   (rsp_bin_base),
      .rsp_count_a    (rsp_count_a),
      .rsp_count_b    (rsp_count_b),
      .rsp_count_c    (rsp_count_c),
      .rsp_count_d    (rsp_count_d),
      .rsp_valid_bins (rsp_valid_bins),
      .rsp_min_value  (rsp_min_value),
      .rsp_max_value  (rsp_max_value),
      .rsp_flat_range (rsp_flat_range),
      .rsp_overflowed (rsp_overflowed)
   );

   assign rsp_last_result = status.grp_last;

endmodule
`default_nettype wire

>>> hdl/arh_ram.sv
`default_nettype none
module arh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/arh_ctrl.sv
`default_nettype none
module arh_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last_item,
   output      logic                    req_stall,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire arh_pkg::arh_status_type status,
   output      arh_pkg::arh_cmd_type    cmd
);

   typedef enum logic [3:0] {
      LOAD, CLEAR, SRD, MUL, DIV, BRD, BWR, ERD, ECAP, OUT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      accept;

   assign req_stall = (state_ff != LOAD);
   assign rsp_valid = valid_ff;
   assign accept    = req_valid && (state_ff == LOAD);

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cmd      = '0;
      unique case (state_ff)
         LOAD: begin
            cmd.store_push = accept;
            if (accept && req_last_item) begin
               state_in = CLEAR;
            end
         end
         CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               if (status.flat) begin
                  cmd.grp_init = 1'b1;
                  state_in     = ERD;
               end else begin
                  state_in = SRD;
               end
            end
         end
         SRD: begin
            if (status.scan_done) begin
               cmd.grp_init = 1'b1;
               state_in     = ERD;
            end else begin
               cmd.smp_read = 1'b1;
               state_in     = MUL;
            end
         end
         MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = BRD;
            end
         end
         BRD: begin
            cmd.bin_read = 1'b1;
            state_in     = BWR;
         end
         BWR: begin
            cmd.bin_write = 1'b1;
            state_in      = SRD;
         end
         ERD: begin
            cmd.grp_read = 1'b1;
            state_in     = ECAP;
         end
         ECAP: begin
            cmd.grp_cap = 1'b1;
            if (status.lane_last) begin
               valid_in = 1'b1;
               state_in = OUT;
            end else begin
               state_in = ERD;
            end
         end
         OUT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               if (status.grp_last) begin
                  cmd.set_restart = 1'b1;
                  state_in        = LOAD;
               end else begin
                  cmd.grp_next = 1'b1;
                  state_in     = ERD;
               end
            end
         end
         default: begin
            state_in = LOAD;
            valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/arh_datapath.sv
`default_nettype none
module arh_datapath #(
   parameter int BINS  = arh_pkg::BINS_DEFAULT,
   parameter int DEPTH = arh_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire arh_pkg::arh_cmd_type                 cmd,
   input  wire logic signed [arh_pkg::SAMPLE_W-1:0]  req_sample,
   output      arh_pkg::arh_status_type              status,
   output      logic [arh_pkg::BASE_W-1:0]           rsp_bin_base,
   output      logic [arh_pkg::COUNT_W-1:0]          rsp_count_a,
   output      logic [arh_pkg::COUNT_W-1:0]          rsp_count_b,
   output      logic [arh_pkg::COUNT_W-1:0]          rsp_count_c,
   output      logic [arh_pkg::COUNT_W-1:0]          rsp_count_d,
   output      logic [arh_pkg::VBINS_W-1:0]          rsp_valid_bins,
   output      logic signed [arh_pkg::SAMPLE_W-1:0]  rsp_min_value,
   output      logic signed [arh_pkg::SAMPLE_W-1:0]  rsp_max_value,
   output      logic                                 rsp_flat_range,
   output      logic                                 rsp_overflowed
);

   localparam int SW  = arh_pkg::SAMPLE_W;
   localparam int CNW = arh_pkg::COUNT_W;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QW  = $clog2(BINS + 1);
   localparam int BW  = (BINS > 1) ? $clog2(BINS) : 1;
   localparam int RW  = SW + QW;
   localparam int STW = (QW > 1) ? $clog2(QW) : 1;
   localparam int IW  = 9;

   // Set statistics.
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic signed [SW-1:0] min_ff, min_in;
   logic signed [SW-1:0] max_ff, max_in;
   logic                 ovf_ff, ovf_in;
   // Scan and divider.
   logic [CW-1:0]        sidx_ff, sidx_in;
   logic [IW-1:0]        cidx_ff, cidx_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [RW-1:0]        dsh_ff, dsh_in;
   logic [QW-1:0]        quot_ff, quot_in;
   logic [STW-1:0]       stp_ff, stp_in;
   // Result assembly.
   logic [IW-1:0]        gbase_ff, gbase_in;
   logic [1:0]           k_ff, k_in;
   logic [CNW-1:0]       lane_ff [arh_pkg::LANES];
   logic [CNW-1:0]       lane_in [arh_pkg::LANES];

   logic                 room;
   logic [SW-1:0]        smp_rdata;
   logic [SW-1:0]        range;
   logic [SW-1:0]        diff;
   logic [CNW-1:0]       bin_rdata;
   logic                 bin_we;
   logic [BW-1:0]        bin_addr;
   logic [CNW-1:0]       bin_wdata;
   logic                 q_ok;
   logic [IW-1:0]        gidx;
   logic                 gidx_ok;
   logic [IW-1:0]        left;

   assign room     = (cnt_ff < CW'(DEPTH));
   assign range    = max_ff - min_ff;
   assign diff     = smp_rdata - min_ff;
   assign q_ok     = (quot_ff < QW'(BINS));
   assign gidx     = gbase_ff + IW'(k_ff);
   assign gidx_ok  = (gidx < IW'(BINS));
   assign left     = IW'(BINS) - gbase_ff;

   arh_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (cmd.store_push && room),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_en   (cmd.smp_read),
      .rd_addr (sidx_ff[AW-1:0]),
      .rd_data (smp_rdata)
   );

   always_comb begin
      if (cmd.clr_write) begin
         bin_addr = cidx_ff[BW-1:0];
      end else if (cmd.grp_read) begin
         bin_addr = gidx[BW-1:0];
      end else begin
         bin_addr = quot_ff[BW-1:0];
      end
      bin_we    = cmd.clr_write || (cmd.bin_write && q_ok);
      bin_wdata = '0;
      if (cmd.bin_write) begin
         bin_wdata = (bin_rdata == arh_pkg::COUNT_MAX) ? bin_rdata : bin_rdata + CNW'(1);
      end
   end

   arh_ram #(.WIDTH(CNW), .DEPTH(BINS)) u_bins (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_addr),
      .wr_data (bin_wdata),
      .rd_en   (cmd.bin_read || cmd.grp_read),
      .rd_addr (bin_addr),
      .rd_data (bin_rdata)
   );

   always_comb begin
      cnt_in   = cnt_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      ovf_in   = ovf_ff;
      sidx_in  = sidx_ff;
      cidx_in  = cidx_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      stp_in   = stp_ff;
      gbase_in = gbase_ff;
      k_in     = k_ff;
      lane_in  = lane_ff;

      if (cmd.store_push) begin
         if (room) begin
            cnt_in = cnt_ff + CW'(1);
            if (req_sample < min_ff) begin
               min_in = req_sample;
            end
            if (req_sample > max_ff) begin
               max_in = req_sample;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.set_restart) begin
         cnt_in  = '0;
         min_in  = {1'b0, {(SW-1){1'b1}}};
         max_in  = {1'b1, {(SW-1){1'b0}}};
         ovf_in  = 1'b0;
         sidx_in = '0;
         cidx_in = '0;
      end
      if (cmd.clr_write) begin
         cidx_in = cidx_ff + IW'(1);
      end
      // The quotient is below 2^QW, so the restoring division starts at bit QW-1.
      if (cmd.mul_load) begin
         rem_in  = RW'(diff) * RW'(BINS);
         dsh_in  = RW'(range) << (QW - 1);
         quot_in = '0;
         stp_in  = '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = (quot_ff << 1) | QW'(1);
         end else begin
            quot_in = quot_ff << 1;
         end
         dsh_in = dsh_ff >> 1;
         stp_in = stp_ff + STW'(1);
      end
      if (cmd.bin_write) begin
         sidx_in = sidx_ff + CW'(1);
      end
      if (cmd.grp_init) begin
         gbase_in = '0;
         k_in     = '0;
      end
      if (cmd.grp_cap) begin
         lane_in[k_ff] = gidx_ok ? bin_rdata : '0;
         k_in          = k_ff + 2'd1;
      end
      if (cmd.grp_next) begin
         gbase_in = gbase_ff + IW'(arh_pkg::LANES);
         k_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         min_ff   <= {1'b0, {(SW-1){1'b1}}};
         max_ff   <= {1'b1, {(SW-1){1'b0}}};
         ovf_ff   <= 1'b0;
         sidx_ff  <= '0;
         cidx_ff  <= '0;
         stp_ff   <= '0;
         gbase_ff <= '0;
         k_ff     <= '0;
      end else begin
         cnt_ff   <= cnt_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         ovf_ff   <= ovf_in;
         sidx_ff  <= sidx_in;
         cidx_ff  <= cidx_in;
         stp_ff   <= stp_in;
         gbase_ff <= gbase_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      lane_ff <= lane_in;
   end

   always_comb begin
      status.clr_last  = (cidx_ff == IW'(BINS - 1));
      status.flat      = (min_ff >= max_ff);
      status.scan_done = (sidx_ff == cnt_ff);
      status.div_last  = (stp_ff == STW'(QW - 1));
      status.lane_last = (k_ff == 2'd3);
      status.grp_last  = ((gbase_ff + IW'(arh_pkg::LANES)) >= IW'(BINS));
   end

   assign rsp_bin_base   = gbase_ff[arh_pkg::BASE_W-1:0];
   assign rsp_count_a    = lane_ff[0];
   assign rsp_count_b    = lane_ff[1];
   assign rsp_count_c    = lane_ff[2];
   assign rsp_count_d    = lane_ff[3];
   assign rsp_valid_bins = (left >= IW'(arh_pkg::LANES)) ? 3'd4 : left[2:0];
   assign rsp_min_value  = min_ff;
   assign rsp_max_value  = max_ff;
   assign rsp_flat_range = status.flat;
   assign rsp_overflowed = ovf_ff;

endmodule
`default_nettype wire

>>> hdl/arh_checker.sv
`default_nettype none
`include "assert_macros.svh"
module arh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [12:0] rsp_count_a,
   input wire logic [2:0]  rsp_valid_bins,
   input wire logic [31:0] rsp_min_value,
   input wire logic [31:0] rsp_max_value,
   input wire logic        rsp_flat_range
);

   // A stalled result keeps its transfer pending with the same count_a.
   `ARH_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count_a))
   // No sample is taken while a result is on offer.
   `ARH_ASSERT_IMP(a_no_load_in_emit, rsp_valid, req_stall)
   `ARH_ASSERT_IMP(a_vbins_range, rsp_valid, rsp_valid_bins >= 3'd1 && rsp_valid_bins <= 3'd4)
   // Every set holds at least one sample, so the flag means min equals max.
   `ARH_ASSERT_IMP(a_flat_flag, rsp_valid, rsp_flat_range == (rsp_min_value == rsp_max_value))

endmodule

bind auto_range_histogram_unit arh_checker u_arh_checker (.*);
`default_nettype wire

>>> tb/sv/auto_range_histogram_checker.sv
`default_nettype none
module auto_range_histogram_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic signed [arh_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic                                req_last_item,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [arh_pkg::BASE_W-1:0]          rsp_bin_base,
   input  wire logic [arh_pkg::COUNT_W-1:0]         rsp_count_a,
   input  wire logic [arh_pkg::COUNT_W-1:0]         rsp_count_b,
   input  wire logic [arh_pkg::COUNT_W-1:0]         rsp_count_c,
   input  wire logic [arh_pkg::COUNT_W-1:0]         rsp_count_d,
   input  wire logic [arh_pkg::VBINS_W-1:0]         rsp_valid_bins,
   input  wire logic signed [arh_pkg::SAMPLE_W-1:0] rsp_min_value,
   input  wire logic signed [arh_pkg::SAMPLE_W-1:0] rsp_max_value,
   input  wire logic                                rsp_flat_range,
   input  wire logic                                rsp_overflowed,
   input  wire logic                                rsp_last_result,
   output int                                       fail_count,
   output int                                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BINS  = arh_pkg::BINS_DEFAULT;
   localparam int STORE_MAX = arh_pkg::DEPTH_DEFAULT;
   localparam int NV_W      = arh_pkg::VBINS_W;
   localparam int CNT_W     = arh_pkg::COUNT_W;

   typedef struct {
      logic [arh_pkg::BASE_W-1:0]          base;
      logic [arh_pkg::COUNT_W-1:0]         cnt [4];
      logic [arh_pkg::VBINS_W-1:0]         nvalid;
      logic signed [arh_pkg::SAMPLE_W-1:0] lo;
      logic signed [arh_pkg::SAMPLE_W-1:0] hi;
      logic                                flat;
      logic                                ovf;
      logic                                fin;
   } bin_group_type;

   bin_group_type                       expected_groups[$];
   logic signed [arh_pkg::SAMPLE_W-1:0] set_samples[$];
   longint                              set_min;
   longint                              set_max;
   logic                                set_ovf;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   task automatic restart_set();
      set_samples.delete();
      set_min = 64'sd2147483647;
      set_max = -64'sd2147483648;
      set_ovf = 1'b0;
   endtask

   // Bins the whole set and queues one group of four counts per result.
   task automatic bin_set();
      int             counts[NUM_BINS];
      longint         d;
      longint         b;
      longint         span;
      logic           flat;
      bin_group_type  g;
      foreach (counts[i]) counts[i] = 0;
      flat = (set_min >= set_max);
      span = set_max - set_min;
      if (!flat) begin
         foreach (set_samples[i]) begin
            d = longint'(set_samples[i]) - set_min;
            b = (d * NUM_BINS) / span;
            if (b < NUM_BINS && counts[b] < int'(arh_pkg::COUNT_MAX)) counts[b]++;
         end
      end
      for (int i = 0; i < NUM_BINS; i += 4) begin
         g.base = i[arh_pkg::BASE_W-1:0];
         g.nvalid = NV_W'((NUM_BINS - i < 4) ? NUM_BINS - i : 4);
         for (int k = 0; k < 4; k++) g.cnt[k] = CNT_W'((k < g.nvalid) ? counts[i + k] : 0);
         g.lo = set_min[31:0];
         g.hi = set_max[31:0];
         g.flat = flat;
         g.ovf = set_ovf;
         g.fin = (i + 4 >= NUM_BINS);
         expected_groups.push_back(g);
      end
   endtask

   always @(posedge clock) begin
      bin_group_type g;
      if (reset) begin
         expected_groups.delete();
         restart_set();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (set_samples.size() < STORE_MAX) begin
               set_samples.push_back(req_sample);
               if (req_sample < set_min) set_min = req_sample;
               if (req_sample > set_max) set_max = req_sample;
            end else begin
               set_ovf = 1'b1;
            end
            if (req_last_item) begin
               bin_set();
               restart_set();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_groups.size() == 0) begin
               report("unexpected result, bin_base", rsp_bin_base, -1);
            end else begin
               g = expected_groups.pop_front();
               if (rsp_bin_base !== g.base) report("bin_base", rsp_bin_base, g.base);
               if (rsp_count_a !== g.cnt[0]) report("count_a", rsp_count_a, g.cnt[0]);
               if (rsp_count_b !== g.cnt[1]) report("count_b", rsp_count_b, g.cnt[1]);
               if (rsp_count_c !== g.cnt[2]) report("count_c", rsp_count_c, g.cnt[2]);
               if (rsp_count_d !== g.cnt[3]) report("count_d", rsp_count_d, g.cnt[3]);
               if (rsp_valid_bins !== g.nvalid)
                  report("valid_bins", rsp_valid_bins, g.nvalid);
               if (rsp_min_value !== g.lo) report("min_value", rsp_min_value, g.lo);
               if (rsp_max_value !== g.hi) report("max_value", rsp_max_value, g.hi);
               if (rsp_flat_range !== g.flat) report("flat_range", rsp_flat_range, g.flat);
               if (rsp_overflowed !== g.ovf) report("overflowed", rsp_overflowed, g.ovf);
               if (rsp_last_result !== g.fin)
                  report("last_result", rsp_last_result, g.fin);
            end
         end
      end
      pending = expected_groups.size();
   end
endmodule
`default_nettype wire

>>> tb/sv/auto_range_histogram_unit_test.sv
`default_nettype none
module auto_range_histogram_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [arh_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic                                req_last_item = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [arh_pkg::BASE_W-1:0]          rsp_bin_base;
   logic [arh_pkg::COUNT_W-1:0]         rsp_count_a, rsp_count_b, rsp_count_c, rsp_count_d;
   logic [arh_pkg::VBINS_W-1:0]         rsp_valid_bins;
   logic signed [arh_pkg::SAMPLE_W-1:0] rsp_min_value, rsp_max_value;
   logic                                rsp_flat_range, rsp_overflowed, rsp_last_result;
   int                                  fail_count;
   int                                  pending;
   int                                  cycle_count = 0;
   int                                  items_sent = 0;

   auto_range_histogram_unit u_top (.*);

   auto_range_histogram_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A quiet window with no idling on either side.
   function automatic logic go_idle();
      return !(cycle_count > 3000 && cycle_count < 9000) && ($urandom_range(99) < 22);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(negedge clock) rsp_stall <= go_idle();

   task automatic send_sample(input logic signed [31:0] value, input logic last);
      while (go_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      req_last_item <= last;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_set(input int n, input int mode);
      logic signed [31:0] base;
      logic signed [31:0] v;
      base = $urandom();
      for (int i = 0; i < n; i++) begin
         case (mode)
            0: v = $urandom();
            1: v = base + $urandom_range(255);
            2: v = base;
            default: v = (i % 2) ? base : base + $urandom_range(3);
         endcase
         send_sample(v, i == n - 1);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single sample: flat range.
      send_sample(32'sd5, 1'b1);
      // Full extremes; the maximum falls outside the last bin.
      send_sample(-32'sd2147483648, 1'b0);
      send_sample(32'sd2147483647, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b1);
      // All equal values.
      send_sample(32'sd77, 1'b0);
      send_sample(32'sd77, 1'b0);
      send_sample(32'sd77, 1'b1);
      // Range of 150 puts each step in its own bin; the maximum falls outside the last bin.
      for (int i = 0; i <= 150; i++) send_sample(32'sd1000 + i, i == 150);
      send_set(2, 0);

      while (items_sent < 350) send_set($urandom_range(1, 16), $urandom_range(3));

      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
